### hw/rtl/prrm_pkg.sv
// ---------------------------------------------------------------------------
// prrm_pkg
// Shared types and constants of the pulse rate RPM meter.
// ---------------------------------------------------------------------------
package prrm_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CH_W       = 4;
  localparam int unsigned MASK_W     = 16;
  localparam int unsigned CALLS_W    = 3;
  localparam int unsigned PPM_FACTOR = 60;

  // divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS  = DATA_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  // APB: 32-bit data, word registers
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;
  localparam logic [APB_AW-3:0] REG_RPM_MASK = 1'b0;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [DATA_W-1:0] pulse_count;
    logic [DATA_W-1:0] now_seconds;
  } prrm_in_t;

  typedef struct packed {
    logic [CH_W-1:0]   out_channel;
    logic [DATA_W-1:0] rpm;
    logic              rpm_updated;
  } prrm_out_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } prrm_state_e;

  typedef struct packed {
    logic load;      // latch input word
    logic calc;      // read channel state, scale, set up divider
    logic div_step;  // one restoring divide step
    logic commit;    // write channel state, load output register
  } prrm_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } prrm_sts_t;

endpackage

### hw/rtl/prrm_stream_if.sv
// ---------------------------------------------------------------------------
// prrm_stream_if
// Valid/ready stream channel carrying one word of type T.
// ---------------------------------------------------------------------------
interface prrm_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

### hw/rtl/prrm_apb_regs.sv
// ---------------------------------------------------------------------------
// prrm_apb_regs
// APB register block holding the RPM channel mask.
// ---------------------------------------------------------------------------
module prrm_apb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [prrm_pkg::APB_AW-1:0] paddr,
  input  logic [prrm_pkg::APB_DW-1:0] pwdata,
  output logic [prrm_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output logic [prrm_pkg::MASK_W-1:0] mask_o
);
  import prrm_pkg::*;

  logic [MASK_W-1:0] mask_q;
  logic              sel_mask;

  assign sel_mask = (paddr[APB_AW-1:2] == REG_RPM_MASK);
  assign pready   = 1'b1;
  assign mask_o   = mask_q;
  assign prdata   = sel_mask ? APB_DW'(mask_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (psel && penable && pwrite && sel_mask) begin
      mask_q <= pwdata[MASK_W-1:0];
    end
  end

endmodule

### hw/rtl/prrm_ctrl.sv
// ---------------------------------------------------------------------------
// prrm_ctrl
// Sequencer: load, calc, divide when needed, commit, one word at a time.
// ---------------------------------------------------------------------------
module prrm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output prrm_pkg::prrm_cmd_t cmd_o,
  input  prrm_pkg::prrm_sts_t sts_i
);
  import prrm_pkg::*;

  prrm_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  // output register may be refilled in the cycle it is drained
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CALC;
      end
      S_CALC: begin
        state_d = sts_i.need_div ? S_DIV : S_FIN;
      end
      S_DIV: begin
        if (sts_i.div_last) state_d = S_FIN;
      end
      S_FIN: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.calc     = (state_q == S_CALC);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.commit   = (state_q == S_FIN) && slot_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("commit while output register still full");

  a_accept_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CALC))
    else $error("accepted word did not enter calc");

  a_div_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && sts_i.div_last) |=> (state_q == S_FIN))
    else $error("divider finished but sequencer did not move to commit");

  a_commit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("commit did not present a result");

endmodule

### hw/rtl/prrm_datapath.sv
// ---------------------------------------------------------------------------
// prrm_datapath
// Per-channel window state, scaling by 60, serial divider, output register.
// ---------------------------------------------------------------------------
module prrm_datapath #(
  parameter int unsigned CHANNELS     = 16,
  parameter int unsigned WINDOW_LIMIT = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  prrm_pkg::prrm_in_t          in_data_i,
  input  logic [prrm_pkg::MASK_W-1:0] mask_i,
  input  prrm_pkg::prrm_cmd_t         cmd_i,
  output prrm_pkg::prrm_sts_t         sts_o,
  output prrm_pkg::prrm_out_t         out_data_o
);
  import prrm_pkg::*;

  // the channel field reaches at most 2^CH_W channels
  localparam int unsigned DEPTH = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0]  start_cnt_q  [DEPTH];
  logic [DATA_W-1:0]  start_time_q [DEPTH];
  logic [CALLS_W-1:0] calls_q      [DEPTH];
  logic [DATA_W-1:0]  rpm_q        [DEPTH];

  prrm_in_t           item_q;
  logic               ch_ok_q, en_q, fwd_q, upd_q;
  logic [DATA_W-1:0]  rem_q, quo_q, dvsr_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  prrm_out_t          out_q;

  logic [IDX_W-1:0]   idx;
  logic               ch_ok, en, fwd;
  logic [DATA_W-1:0]  cnt_rd, time_rd, rpm_rd;
  logic [CALLS_W-1:0] calls_rd;
  logic [DATA_W-1:0]  elapsed, scaled;
  logic [DATA_W:0]    shifted, trial;
  logic               fits;
  logic [DATA_W-1:0]  rpm_new;

  assign idx      = item_q.channel[IDX_W-1:0];
  assign ch_ok    = (32'(item_q.channel) < CHANNELS);
  assign cnt_rd   = start_cnt_q[idx];
  assign time_rd  = start_time_q[idx];
  assign calls_rd = calls_q[idx];
  assign rpm_rd   = rpm_q[idx];
  assign en       = ch_ok && mask_i[item_q.channel];
  assign fwd      = (cnt_rd <= item_q.pulse_count);
  assign elapsed  = item_q.now_seconds - time_rd;
  // product wraps to 32 bits before the divide
  assign scaled   = DATA_W'((item_q.pulse_count - cnt_rd) * PPM_FACTOR);

  assign sts_o.need_div = en && fwd && (elapsed != '0);
  assign sts_o.div_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

  // restoring step
  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign trial   = shifted - {1'b0, dvsr_q};
  assign fits    = (shifted >= {1'b0, dvsr_q});

  assign rpm_new    = upd_q ? quo_q : rpm_rd;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.calc) begin
      ch_ok_q <= ch_ok;
      en_q    <= en;
      fwd_q   <= fwd;
      upd_q   <= sts_o.need_div;
      rem_q   <= '0;
      quo_q   <= scaled;
      dvsr_q  <= elapsed;
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_q <= {quo_q[DATA_W-2:0], fits};
    end
    if (cmd_i.commit) begin
      out_q.out_channel <= item_q.channel;
      out_q.rpm         <= ch_ok_q ? rpm_new : '0;
      out_q.rpm_updated <= upd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.calc) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        start_cnt_q[i]  <= '0;
        start_time_q[i] <= '0;
        calls_q[i]      <= '0;
        rpm_q[i]        <= '0;
      end
    end else if (cmd_i.commit && en_q) begin
      if (upd_q) begin
        rpm_q[idx] <= quo_q;
      end
      // count went backwards, or window full: restart at this sample
      if (!fwd_q || (calls_rd >= CALLS_W'(WINDOW_LIMIT))) begin
        start_cnt_q[idx]  <= item_q.pulse_count;
        start_time_q[idx] <= item_q.now_seconds;
        calls_q[idx]      <= '0;
      end else begin
        calls_q[idx] <= calls_rd + CALLS_W'(1);
      end
    end
  end

endmodule

### hw/rtl/pulse_rate_rpm_meter_core.sv
// ---------------------------------------------------------------------------
// pulse_rate_rpm_meter_core
// Windowed per-channel pulse rate tachometer with APB channel mask.
// ---------------------------------------------------------------------------
// Flow: an accepted word passes through calc, the restoring divide steps
//   (skipped when no divide is needed) and commit, which loads the output register.
// A new word is taken only after the previous one is committed; the divider
//   is a one-bit-per-cycle restoring divider. Input is taken while a result waits.
// Reset: asynchronous, active low; clears the mask and all channel state.
module pulse_rate_rpm_meter_core #(
  parameter int unsigned CHANNELS     = 16,
  parameter int unsigned WINDOW_LIMIT = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  prrm_stream_if.sink                 in_i,
  prrm_stream_if.source               out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [prrm_pkg::APB_AW-1:0] paddr,
  input  logic [prrm_pkg::APB_DW-1:0] pwdata,
  output logic [prrm_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import prrm_pkg::*;

  logic [MASK_W-1:0] mask;
  prrm_cmd_t         cmd;
  prrm_sts_t         sts;

  prrm_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mask_o  (mask)
  );

  prrm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  prrm_datapath #(
    .CHANNELS     (CHANNELS),
    .WINDOW_LIMIT (WINDOW_LIMIT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_i.data),
    .mask_i     (mask),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_o.data)
  );

endmodule
